// ===== rtl/accel_tilt_angle_unit_assert.svh =====
// Assertion macros for the tilt angle unit RTL.
`ifndef ACCEL_TILT_ANGLE_UNIT_ASSERT_SVH
`define ACCEL_TILT_ANGLE_UNIT_ASSERT_SVH

// Property must hold in the same cycle as the trigger.
`define ATU_ASSERT_NOW(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error("tilt angle unit: assertion failed");

// Property must hold in the cycle after the trigger.
`define ATU_ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("tilt angle unit: assertion failed");

`endif

// ===== rtl/atu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package atu_pkg;

   typedef enum logic [1:0] {
      FUNC_ASIN  = 2'd0,
      FUNC_ATAN2 = 2'd1,
      FUNC_TILT  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int ANG_FRAC = 20;
   localparam int ANG_W    = 28;
   localparam int CORD_W   = 44;
   localparam int Z_W      = 30;

   localparam logic [ANG_W-1:0] ANG_90  = 28'd94371840;
   localparam logic [ANG_W-1:0] ANG_180 = 28'd188743680;

   localparam logic [CORD_W-1:0] NORM_COARSE = 44'h001_0000_0000;
   localparam logic [CORD_W-1:0] NORM_LIMIT  = 44'h100_0000_0000;

   localparam logic [15:0] COUNTS_PER_G_RESET = 16'd16384;

   // atan(2^-i) in degrees, 20 fraction bits
   function automatic logic [25:0] atan_deg(input logic [4:0] idx);
      logic [25:0] r;
      case (idx)
         5'd0:  r = 26'd47185920;
         5'd1:  r = 26'd27855475;
         5'd2:  r = 26'd14718068;
         5'd3:  r = 26'd7471121;
         5'd4:  r = 26'd3750058;
         5'd5:  r = 26'd1876857;
         5'd6:  r = 26'd938658;
         5'd7:  r = 26'd469357;
         5'd8:  r = 26'd234682;
         5'd9:  r = 26'd117342;
         5'd10: r = 26'd58671;
         5'd11: r = 26'd29335;
         5'd12: r = 26'd14668;
         5'd13: r = 26'd7334;
         5'd14: r = 26'd3667;
         5'd15: r = 26'd1833;
         5'd16: r = 26'd917;
         5'd17: r = 26'd458;
         5'd18: r = 26'd229;
         5'd19: r = 26'd115;
         5'd20: r = 26'd57;
         5'd21: r = 26'd29;
         5'd22: r = 26'd14;
         5'd23: r = 26'd7;
         5'd24: r = 26'd4;
         5'd25: r = 26'd2;
         5'd26: r = 26'd1;
         default: r = 26'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/atu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface atu_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic [1:0]                    first_axis;
   logic [1:0]                    second_axis;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, func, first_axis, second_axis, accel_x, accel_y, accel_z,
                   input ready);
   modport sink (input valid, func, first_axis, second_axis, accel_x, accel_y, accel_z,
                 output ready);
endinterface

interface atu_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] angle_deg;
   logic              degenerate;

   modport source (output valid, angle_deg, degenerate, input ready);
   modport sink (input valid, angle_deg, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/accel_tilt_angle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel     Dir  Handshake      Payload
// req_chan    in   valid/ready    func, first_axis, second_axis, accel_x/y/z
// rsp_chan    out  valid/ready    angle_deg, degenerate
// csr_*       in   csr_we         csr_wdata = counts_per_g
//
// One request at a time; ready is high only while the sequencer is idle.
// From accept to result, atan2 goes from dispatch straight to the CORDIC;
// asin and tilt first square, sum and take the square root. The CORDIC
// normalizes its operands, then rotates, stopping early once y is zero.
// A saturated asin, a zero operand or func 3 skips ahead to the result.
// Reset is synchronous; counts_per_g returns to 16384. A held result stalls
// the sequencer in its last state until the output register is free.
module accel_tilt_angle_unit #(
   parameter int SAMPLE_BITS  = 16,
   parameter int CORDIC_STEPS = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   atu_req_if.sink    req_chan,
   atu_rsp_if.source  rsp_chan,
   input  wire logic  csr_we,
   input  wire logic [15:0] csr_wdata
);
`include "accel_tilt_angle_unit_assert.svh"

   localparam int S     = SAMPLE_BITS;
   localparam int MW    = (S > 16) ? S : 16;
   localparam int RAD_W = 2 * MW + 16;
   localparam int OPW   = RAD_W / 2;
   localparam int AW    = atu_pkg::ANG_W;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DISPATCH = 9'b000000010,
      ST_SQ1      = 9'b000000100,
      ST_SQ2      = 9'b000001000,
      ST_SUM      = 9'b000010000,
      ST_ROOT     = 9'b000100000,
      ST_ASTART   = 9'b001000000,
      ST_ANG      = 9'b010000000,
      ST_FIN      = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [15:0]            cpg_ff;
   atu_pkg::func_type      func_ff, func_in;
   logic [1:0]             ax1_ff, ax1_in, ax2_ff, ax2_in;
   logic [2:0][S-1:0]      mag_ff, mag_in;
   logic [2:0]             neg_ff, neg_in;
   logic [2*MW-1:0]        sum_ff, sum_in, sq_ff, sq_in, product;
   logic [MW-1:0]          mul_op;
   logic [OPW-1:0]         ym_ff, ym_in, xm_ff, xm_in;
   logic                   yneg_ff, yneg_in, xneg_ff, xneg_in, flag_ff, flag_in;
   logic [AW-1:0]          ang_ff, ang_in, fin_mag;
   logic [15:0]            cpg_eff;
   logic [1:0]             o1, o2;
   logic [S-1:0]           a_mag;
   logic [RAD_W-1:0]       radicand;
   logic                   sqrt_start, sqrt_done, cord_start, cord_done;
   logic [OPW-1:0]         root;
   logic [AW-1:0]          cord_angle;
   logic [7:0]             deg;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_flag_ff, rsp_flag_in;
   logic signed [8:0]      rsp_angle_ff, rsp_angle_in;
   logic [2:0][S-1:0]      raw;
   logic                   req_fire;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign raw            = {req_chan.accel_z, req_chan.accel_y, req_chan.accel_x};

   // sensitivity of zero counts as one
   assign cpg_eff = (cpg_ff == 16'd0) ? 16'd1 : cpg_ff;
   // the two axes other than the tilt axis
   assign o1      = (ax1_ff == atu_pkg::AXIS_X) ? atu_pkg::AXIS_Y : atu_pkg::AXIS_X;
   assign o2      = (ax1_ff == atu_pkg::AXIS_Z) ? atu_pkg::AXIS_Y : atu_pkg::AXIS_Z;
   assign a_mag   = mag_ff[ax1_ff];

   // shared squarer: the operand changes with the step
   always_comb begin
      if (state_ff == ST_SQ1) begin
         mul_op = (func_ff == atu_pkg::FUNC_ASIN) ? MW'(cpg_eff) : MW'(mag_ff[o1]);
      end else begin
         mul_op = (func_ff == atu_pkg::FUNC_ASIN) ? MW'(a_mag) : MW'(mag_ff[o2]);
      end
      product = mul_op * mul_op;
   end

   // radicand: (c^2 - a^2) or (p^2 + q^2), scaled by 2^16
   assign radicand   = (func_ff == atu_pkg::FUNC_ASIN) ? {sum_ff - sq_ff, 16'd0}
                                                       : {sum_ff + sq_ff, 16'd0};
   assign sqrt_start = (state_ff == ST_SUM);
   assign cord_start = (state_ff == ST_ASTART) && (ym_ff != '0) && (xm_ff != '0);

   atu_isqrt #(.RAD_W(RAD_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   atu_cordic #(.OPW(OPW), .STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cord_start),
      .y_mag  (ym_ff),
      .x_mag  (xm_ff),
      .done   (cord_done),
      .angle  (cord_angle)
   );

   // quadrant fold, truncate to whole degrees, apply sign
   assign fin_mag      = xneg_ff ? (atu_pkg::ANG_180 - ang_ff) : ang_ff;
   assign deg          = fin_mag[atu_pkg::ANG_FRAC +: 8];

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      ax1_in       = ax1_ff;
      ax2_in       = ax2_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      ym_in        = ym_ff;
      xm_in        = xm_ff;
      yneg_in      = yneg_ff;
      xneg_in      = xneg_ff;
      flag_in      = flag_ff;
      ang_in       = ang_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in = atu_pkg::func_type'(req_chan.func);
               // axis code 3 selects Z
               ax1_in  = (req_chan.first_axis == 2'd3) ? atu_pkg::AXIS_Z
                                                       : req_chan.first_axis;
               ax2_in  = (req_chan.second_axis == 2'd3) ? atu_pkg::AXIS_Z
                                                        : req_chan.second_axis;
               for (int k = 0; k < 3; k++) begin
                  neg_in[k] = raw[k][S-1];
                  mag_in[k] = raw[k][S-1] ? S'(0) - raw[k] : raw[k];
               end
               flag_in  = 1'b0;
               xneg_in  = 1'b0;
               yneg_in  = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (func_ff)
               atu_pkg::FUNC_ASIN: begin
                  if (MW'(a_mag) > MW'(cpg_eff)) begin
                     // beyond 1 g: saturate
                     ang_in   = atu_pkg::ANG_90;
                     yneg_in  = neg_ff[ax1_ff];
                     flag_in  = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_SQ1;
                  end
               end
               atu_pkg::FUNC_ATAN2: begin
                  ym_in    = OPW'(a_mag);
                  yneg_in  = neg_ff[ax1_ff];
                  xm_in    = OPW'(mag_ff[ax2_ff]);
                  xneg_in  = neg_ff[ax2_ff];
                  state_in = ST_ASTART;
               end
               atu_pkg::FUNC_TILT: state_in = ST_SQ1;
               default: begin
                  ang_in   = '0;
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_SQ1: begin
            sq_in    = product;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            sum_in   = sq_ff;
            sq_in    = product;
            state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) begin
               if (func_ff == atu_pkg::FUNC_TILT && ax1_ff == atu_pkg::AXIS_Z) begin
                  // atan(hypot(x,y)/|z|), sign of z applied afterwards
                  ym_in   = root;
                  xm_in   = OPW'(mag_ff[2]) << 8;
               end else begin
                  ym_in   = OPW'(a_mag) << 8;
                  xm_in   = root;
               end
               yneg_in  = neg_ff[ax1_ff];
               xneg_in  = 1'b0;
               state_in = ST_ASTART;
            end
         end
         ST_ASTART: begin
            if (ym_ff == '0 && xm_ff == '0) begin
               ang_in   = '0;
               xneg_in  = 1'b0;
               flag_in  = 1'b1;
               state_in = ST_FIN;
            end else if (xm_ff == '0) begin
               ang_in   = atu_pkg::ANG_90;
               state_in = ST_FIN;
            end else if (ym_ff == '0) begin
               ang_in   = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_ANG;
            end
         end
         ST_ANG: begin
            if (cord_done) begin
               ang_in   = cord_angle;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = yneg_ff ? 9'sd0 - $signed({1'b0, deg})
                                      : $signed({1'b0, deg});
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cpg_ff       <= atu_pkg::COUNTS_PER_G_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cpg_ff <= csr_wdata;
         end
      end
      func_ff      <= func_in;
      ax1_ff       <= ax1_in;
      ax2_ff       <= ax2_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sum_ff       <= sum_in;
      sq_ff        <= sq_in;
      ym_ff        <= ym_in;
      xm_ff        <= xm_in;
      yneg_ff      <= yneg_in;
      xneg_ff      <= xneg_in;
      flag_ff      <= flag_in;
      ang_ff       <= ang_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.angle_deg  = rsp_angle_ff;
   assign rsp_chan.degenerate = rsp_flag_ff;

   `ATU_ASSERT_NEXT(a_fire_dispatch, clock, reset, req_fire, state_ff == ST_DISPATCH)
   `ATU_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FIN))
   `ATU_ASSERT_NOW(a_angle_range, clock, reset, rsp_valid_ff,
                   rsp_angle_ff >= -9'sd180 && rsp_angle_ff <= 9'sd180)
   `ATU_ASSERT_NOW(a_cord_done_wait, clock, reset, cord_done, state_ff == ST_ANG)
endmodule
`default_nettype wire

// ===== rtl/atu_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Floor square root, one result bit per cycle.
module atu_isqrt #(
   parameter int RAD_W = 48
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RAD_W-1:0]   radicand,
   output logic                    done,
   output logic [RAD_W/2-1:0]      root
);
   logic [RAD_W-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = res_ff + bit_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RAD_W-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[RAD_W/2-1:0];
endmodule
`default_nettype wire

// ===== rtl/atu_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Vectoring CORDIC in the first quadrant; operands must both be nonzero.
module atu_cordic #(
   parameter int OPW   = 24,
   parameter int STEPS = 20
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [OPW-1:0]             y_mag,
   input  wire logic [OPW-1:0]             x_mag,
   output logic                            done,
   output logic [atu_pkg::ANG_W-1:0]       angle
);
   localparam int CW = $clog2(STEPS + 1);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_NORM = 3'b010,
      CS_ITER = 3'b100
   } cstate_type;

   cstate_type                           state_ff, state_in;
   logic signed [atu_pkg::CORD_W-1:0]    x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [atu_pkg::Z_W-1:0]       z_ff, z_in, tab;
   logic [CW-1:0]                        cnt_ff, cnt_in;
   logic [4:0]                           idx;
   logic [atu_pkg::CORD_W-1:0]           mx;
   logic                                 done_ff, done_in;

   always_comb begin
      idx      = 5'(cnt_ff);
      dx       = y_ff >>> idx;
      dy       = x_ff >>> idx;
      tab      = atu_pkg::Z_W'(atu_pkg::atan_deg(idx));
      mx       = (x_ff > y_ff) ? x_ff : y_ff;
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               x_in     = atu_pkg::CORD_W'(x_mag);
               y_in     = atu_pkg::CORD_W'(y_mag);
               z_in     = '0;
               cnt_in   = '0;
               state_in = CS_NORM;
            end
         end
         CS_NORM: begin
            // coarse step first while far below the limit
            if (mx < atu_pkg::NORM_COARSE) begin
               x_in = x_ff <<< 8;
               y_in = y_ff <<< 8;
            end else if (mx < atu_pkg::NORM_LIMIT) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               state_in = CS_ITER;
            end
         end
         CS_ITER: begin
            if (cnt_ff == CW'(STEPS) || y_ff == '0) begin
               done_in  = 1'b1;
               state_in = CS_IDLE;
            end else begin
               if (y_ff > 0) begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + tab;
               end else begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - tab;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

   // clamp to [0, 90] degrees
   always_comb begin
      if (z_ff < 0) begin
         angle = '0;
      end else if (z_ff > atu_pkg::Z_W'(atu_pkg::ANG_90)) begin
         angle = atu_pkg::ANG_90;
      end else begin
         angle = atu_pkg::ANG_W'(z_ff);
      end
   end

   assign done = done_ff;
endmodule
`default_nettype wire

// ===== verif/tilt_angle_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   atu_req_if.sink          req_mon,
   atu_rsp_if.sink          rsp_mon,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   import atu_pkg::*;

   typedef struct packed {
      logic signed [8:0] angle_deg;
      logic              degenerate;
   } angle_result_type;

   localparam longint ONE_DEG = 64'sd1 << ANG_FRAC;

   logic [15:0]      sensitivity;
   angle_result_type angle_queue[$];

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // first-quadrant CORDIC vectoring plus quadrant fixup
   function automatic longint vector_angle(input longint unsigned ym, input bit yneg,
                                           input longint unsigned xm, input bit xneg,
                                           inout bit flag);
      longint mag, deg, x, y, z, dx, dy;
      int i;
      if (ym == 0 && xm == 0) begin
         flag = 1;
         return 0;
      end
      if (xm == 0) begin
         mag = 90 * ONE_DEG;
      end else if (ym == 0) begin
         mag = 0;
      end else begin
         while ((xm > ym ? xm : ym) < (64'd1 << 40)) begin
            xm <<= 1;
            ym <<= 1;
         end
         x = xm;
         y = ym;
         z = 0;
         for (i = 0; i < 20 && y != 0; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += longint'(atan_deg(i[4:0]));
            end else begin
               x -= dx; y += dy; z -= longint'(atan_deg(i[4:0]));
            end
         end
         if (z < 0) z = 0;
         if (z > 90 * ONE_DEG) z = 90 * ONE_DEG;
         mag = z;
      end
      if (xneg) mag = 180 * ONE_DEG - mag;
      deg = mag >>> ANG_FRAC;
      return yneg ? -deg : deg;
   endfunction

   function automatic angle_result_type predict_angle(input logic [1:0] fn,
         input logic [1:0] ax1, input logic [1:0] ax2,
         input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az);
      longint unsigned mag[3];
      bit neg[3];
      logic [15:0] raw[3];
      longint ang, c, a, h;
      bit flag;
      int o1, o2, k, p1, p2;
      angle_result_type r;
      raw[0] = ax; raw[1] = ay; raw[2] = az;
      for (k = 0; k < 3; k++) begin
         neg[k] = raw[k][15];
         mag[k] = neg[k] ? 65536 - raw[k] : raw[k];
      end
      p1 = (ax1 > AXIS_Z) ? 2 : ax1;
      p2 = (ax2 > AXIS_Z) ? 2 : ax2;
      ang = 0;
      flag = 0;
      case (fn)
         FUNC_ASIN: begin
            c = (sensitivity == 0) ? 1 : sensitivity;
            a = mag[p1];
            if (a > c) begin
               flag = 1;
               ang = neg[p1] ? -90 : 90;
            end else begin
               h = int_sqrt((c * c - a * a) << 16);
               ang = vector_angle(a << 8, neg[p1], h, 0, flag);
            end
         end
         FUNC_ATAN2: ang = vector_angle(mag[p1], neg[p1], mag[p2], neg[p2], flag);
         FUNC_TILT: begin
            o1 = (p1 == 0) ? 1 : 0;
            o2 = (p1 == 2) ? 1 : 2;
            h = int_sqrt((mag[o1] * mag[o1] + mag[o2] * mag[o2]) << 16);
            if (p1 == 2) begin
               ang = vector_angle(h, 0, mag[2] << 8, 0, flag);
               if (neg[2]) ang = -ang;
            end else begin
               ang = vector_angle(mag[p1] << 8, neg[p1], h, 0, flag);
            end
         end
         default: ;
      endcase
      r.angle_deg = ang[8:0];
      r.degenerate = flag;
      return r;
   endfunction

   assign pending_count = angle_queue.size();

   always @(posedge clock) begin
      angle_result_type want;
      if (reset) begin
         sensitivity <= COUNTS_PER_G_RESET;
         angle_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) sensitivity <= csr_wdata;
         if (req_mon.valid && req_mon.ready)
            angle_queue.push_back(predict_angle(req_mon.func, req_mon.first_axis,
               req_mon.second_axis, req_mon.accel_x, req_mon.accel_y, req_mon.accel_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected result angle=%0d degenerate=%0b", $time,
                        rsp_mon.angle_deg, rsp_mon.degenerate);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (want.angle_deg !== rsp_mon.angle_deg ||
                   want.degenerate !== rsp_mon.degenerate) begin
                  $display("%0t: expected angle=%0d degenerate=%0b, got angle=%0d degenerate=%0b",
                           $time, want.angle_deg, want.degenerate,
                           rsp_mon.angle_deg, rsp_mon.degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import atu_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = 0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_rsp = 0;
   int          quiet_cycles = 0;

   atu_req_if req_chan ();
   atu_rsp_if rsp_chan ();

   accel_tilt_angle_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   tilt_angle_checker angle_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.func = FUNC_ASIN;
      req_chan.first_axis = AXIS_X;
      req_chan.second_axis = AXIS_X;
      req_chan.accel_x = 0;
      req_chan.accel_y = 0;
      req_chan.accel_z = 0;
      rsp_chan.ready = 0;
   end

   // Stall the receiver at random; a long hold-off overrides the random choice.
   always @(posedge clock) begin
      if (hold_rsp)
         rsp_chan.ready <= 0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles without any accepted transfer.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [1:0] fn, input logic [1:0] ax1,
                               input logic [1:0] ax2, input logic [15:0] ax,
                               input logic [15:0] ay, input logic [15:0] az);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_chan.valid <= 1;
      req_chan.func <= fn;
      req_chan.first_axis <= ax1;
      req_chan.second_axis <= ax2;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.accel_z <= az;
      do @(posedge clock); while (!req_chan.ready);
      req_chan.valid <= 0;
      // the block is not idle right after an accept, so this edge costs nothing
      @(posedge clock);
   endtask

   // Wait for every expected result, then let the sequencer settle.
   task automatic drain_results();
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_sensitivity(input logic [15:0] value);
      drain_results();
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Pick a reading: mostly random, sometimes an extreme, near zero or near +/- sens.
   function automatic logic [15:0] pick_reading(input logic [15:0] sens);
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(4)) - 16'd2;
         3: return ($urandom_range(1) ? sens : -sens);
         4: return sens + 16'($urandom_range(2)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count, input logic [15:0] sens);
      logic [1:0] fn;
      int n;
      for (n = 0; n < count; n++) begin
         fn = ($urandom_range(19) == 0) ? FUNC_NONE : 2'($urandom_range(2));
         send_request(fn, 2'($urandom_range(3)), 2'($urandom_range(3)),
                      pick_reading(sens), pick_reading(sens), pick_reading(sens));
      end
   endtask

   logic [15:0] sens_list[5] = '{16'd16384, 16'd1, 16'd0, 16'hffff, 16'd2048};
   int          ph;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: each function, the zero-axis cases, saturation, and axis code 3.
      send_request(FUNC_ASIN, AXIS_X, AXIS_X, 16'd0, 16'd0, 16'd0);
      send_request(FUNC_ASIN, AXIS_X, AXIS_X, 16'd16384, 16'd0, 16'd0);
      send_request(FUNC_ASIN, AXIS_Y, AXIS_X, 16'd0, -16'sd16384, 16'd0);
      send_request(FUNC_ASIN, AXIS_Z, AXIS_X, 16'd0, 16'd0, 16'd16385);
      send_request(FUNC_ASIN, 2'd3, AXIS_X, 16'd0, 16'd0, 16'h8000);
      send_request(FUNC_ASIN, AXIS_X, AXIS_X, 16'd8192, 16'd0, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'd0, 16'd0, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'd100, 16'd0, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, -16'sd100, 16'd0, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'd0, 16'd100, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'd0, -16'sd100, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'h8000, 16'h8000, 16'd0);
      send_request(FUNC_ATAN2, AXIS_X, AXIS_Y, 16'h7fff, 16'h8000, 16'd0);
      send_request(FUNC_ATAN2, AXIS_Z, 2'd3, 16'd0, 16'd0, 16'd5);
      send_request(FUNC_TILT, AXIS_X, AXIS_X, 16'd0, 16'd0, 16'd0);
      send_request(FUNC_TILT, AXIS_X, AXIS_X, 16'd1000, 16'd1000, 16'd1000);
      send_request(FUNC_TILT, AXIS_Y, AXIS_X, 16'd0, -16'sd1000, 16'd0);
      send_request(FUNC_TILT, AXIS_Z, AXIS_X, 16'd300, 16'd400, -16'sd500);
      send_request(FUNC_TILT, AXIS_Z, AXIS_X, 16'd0, 16'd0, 16'd7);
      send_request(FUNC_TILT, 2'd3, AXIS_X, 16'h8000, 16'h8000, 16'h8000);
      send_request(FUNC_NONE, AXIS_Y, AXIS_Z, 16'h7fff, 16'h7fff, 16'h7fff);

      // Long receiver hold-off while requests keep coming: fill up and stall.
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         random_phase(6, 16'd16384);
      join

      // Random: sweep sensitivities and idling patterns.
      for (ph = 0; ph < 20; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         if (ph % 4 == 0) write_sensitivity(sens_list[(ph / 4) % 5]);
         random_phase(40, (sens_list[(ph / 4) % 5] == 0) ? 16'd1 : sens_list[(ph / 4) % 5]);
         if (ph == 9) drain_results();
      end

      drain_results();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/atu_pkg.sv
rtl/atu_if.sv
rtl/atu_isqrt.sv
rtl/atu_cordic.sv
rtl/accel_tilt_angle_unit.sv
verif/tilt_angle_checker.sv
verif/testbench.sv
